FILE: hdl/fbc_pkg.sv
// shared constants, types and helpers of the frustum box cull block
package fbc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int PLANE_COUNT   = 6;
    localparam int COORD_W       = 32;
    // coefficient after the floor shift of a 67-bit exact sum
    localparam int COEF_W        = 2 * COORD_W + 3 - FRACTION_BITS;
    localparam int LO_W          = COEF_W / 2;
    localparam int HI_W          = COEF_W - LO_W;
    localparam int TERM_W        = COORD_W + COEF_W;
    localparam int SUM_W         = TERM_W + 2;
    localparam int PSUM_W        = COORD_W + 1;
    localparam int PROD_W        = PSUM_W + COORD_W;
    localparam int ACC_W         = PROD_W + 2;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_BUILD = 2'd1;
    localparam logic [1:0] OP_TEST  = 2'd2;

    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic [3:0][COEF_W-1:0]   t_plane;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
    } t_box;

    typedef struct packed {
        logic valid;
        logic last;
    } t_test_tag;

    typedef struct packed {
        logic       valid;
        logic [1:0] coef;
        logic       last;
    } t_gen_tag;

    // matrix row paired with row 3 for each plane
    function automatic logic [1:0] plane_row(input logic [2:0] p);
        logic [1:0] r;
        unique case (p)
            3'd0, 3'd1: r = 2'd0;
            3'd2, 3'd3: r = 2'd1;
            default:    r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic plane_minus(input logic [2:0] p);
        return (p == 3'd1) || (p == 3'd2) || (p == 3'd5);
    endfunction

endpackage

FILE: hdl/fbc_if.sv
// request and result channel interfaces of the frustum box cull block
interface fbc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;

    modport source (
        output valid, operation, element_index, element_value,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        input  ready
    );
    modport sink (
        input  valid, operation, element_index, element_value,
               box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
        output ready
    );
endinterface

interface fbc_res_if;
    logic valid;
    logic ready;
    logic box_visible;

    modport source (output valid, box_visible, input ready);
    modport sink (input valid, box_visible, output ready);
endinterface

FILE: hdl/frustum_box_cull.sv
// frustum box cull top level: control, view matrix, plane chain
//
// usage: requests arrive on i_req (valid/ready), results leave on o_res.
// operation load writes one view matrix element; the block stays idle.
// operation build forms the six clip planes from projection (config port)
// times view: one coefficient per cycle through a shared four-multiplier
// unit, followed by a drain of the generator pipeline.
// operation test rotates the six-cell plane chain past one test unit, one
// plane per cycle; the request then passes through test drain and done,
// and the next request is taken only back in idle, so a new box is not
// taken before the last one is through. only test produces a result.
// i_req.ready is high only while no request is in flight.
// the result sits in an output register; a new request may be taken while
// it waits. if a second test finishes before the first result is taken,
// the block holds until o_res.ready.
// reset clears projection, view matrix and planes to zero; a test before
// any build reports not visible.
module frustum_box_cull (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fbc_req_if.sink     i_req,
    fbc_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_BUILD  = 3'd1;
    localparam logic [2:0] ST_BDRAIN = 3'd2;
    localparam logic [2:0] ST_TEST   = 3'd3;
    localparam logic [2:0] ST_TDRAIN = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]          r_state;
    logic [4:0]          r_cnt;
    logic [63:0]         r_proj [8];
    logic [3:0][31:0]    r_view [4];
    fbc_pkg::t_box       r_box;
    fbc_pkg::t_coef      r_asm [3];
    logic                r_vis;
    logic                r_out_valid;
    logic                r_out_vis;

    fbc_pkg::t_plane     w_plane [fbc_pkg::PLANE_COUNT];
    fbc_pkg::t_plane     w_next  [fbc_pkg::PLANE_COUNT];
    fbc_pkg::t_plane     w_new_plane;
    logic                w_shift;
    logic                w_insert;
    logic                w_accept;

    logic signed [3:0][fbc_pkg::PSUM_W-1:0] w_psum;
    fbc_pkg::t_gen_tag   w_gen_in;
    fbc_pkg::t_gen_tag   w_gen_out;
    fbc_pkg::t_coef      w_gen_coef;
    fbc_pkg::t_test_tag  w_test_in;
    fbc_pkg::t_test_tag  w_test_out;
    logic                w_inside;

    logic [1:0]          w_row;
    logic                w_minus;

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.box_visible = r_out_vis;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_proj[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_proj[i_cfg_index] <= i_cfg_data;
        end
    end

    // view matrix, stored by column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_view[i] <= '0;
            end
        end else if (w_accept && i_req.operation == fbc_pkg::OP_LOAD) begin
            r_view[i_req.element_index[3:2]][i_req.element_index[1:0]] <=
                i_req.element_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_req.operation == fbc_pkg::OP_TEST) begin
            r_box.min_x <= i_req.box_min_x;
            r_box.min_y <= i_req.box_min_y;
            r_box.min_z <= i_req.box_min_z;
            r_box.max_x <= i_req.box_max_x;
            r_box.max_y <= i_req.box_max_y;
            r_box.max_z <= i_req.box_max_z;
        end
    end

    // projection row 3 plus or minus the plane's row, per k
    assign w_row   = fbc_pkg::plane_row(r_cnt[4:2]);
    assign w_minus = fbc_pkg::plane_minus(r_cnt[4:2]);

    always_comb begin
        logic signed [31:0] w3;
        logic signed [31:0] wo;
        for (int k = 0; k < 4; k++) begin
            w3 = $signed(r_proj[2*k+1][63:32]);
            unique case (w_row)
                2'd0:    wo = $signed(r_proj[2*k][31:0]);
                2'd1:    wo = $signed(r_proj[2*k][63:32]);
                default: wo = $signed(r_proj[2*k+1][31:0]);
            endcase
            w_psum[k] = w_minus ? (fbc_pkg::PSUM_W'(w3) - fbc_pkg::PSUM_W'(wo))
                                : (fbc_pkg::PSUM_W'(w3) + fbc_pkg::PSUM_W'(wo));
        end
    end

    always_comb begin
        w_gen_in.valid = (r_state == ST_BUILD);
        w_gen_in.coef  = r_cnt[1:0];
        w_gen_in.last  = (r_cnt == 5'd23);
        w_test_in.valid = (r_state == ST_TEST);
        w_test_in.last  = (r_cnt[2:0] == 3'(fbc_pkg::PLANE_COUNT - 1));
    end

    fbc_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_gen_in),
        .i_psum  (w_psum),
        .i_view  (r_view[r_cnt[1:0]]),
        .o_tag   (w_gen_out),
        .o_coef  (w_gen_coef)
    );

    fbc_test u_test (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_test_in),
        .i_plane  (w_plane[0]),
        .i_box    (r_box),
        .o_tag    (w_test_out),
        .o_inside (w_inside)
    );

    // assemble the four coefficients of a plane
    always_ff @(posedge i_clk) begin
        if (w_gen_out.valid) begin
            unique case (w_gen_out.coef)
                2'd0:    r_asm[0] <= w_gen_coef;
                2'd1:    r_asm[1] <= w_gen_coef;
                2'd2:    r_asm[2] <= w_gen_coef;
                default: ;
            endcase
        end
    end

    assign w_new_plane = {w_gen_coef, r_asm[2], r_asm[1], r_asm[0]};
    assign w_insert    = w_gen_out.valid && (w_gen_out.coef == 2'd3);
    assign w_shift     = (r_state == ST_TEST) || w_insert;

    // plane chain: rotate during test, new plane enters at the tail on build
    always_comb begin
        for (int i = 0; i < fbc_pkg::PLANE_COUNT - 1; i++) begin
            w_next[i] = w_plane[i+1];
        end
        w_next[fbc_pkg::PLANE_COUNT-1] = (r_state == ST_TEST) ? w_plane[0] : w_new_plane;
    end

    for (genvar g = 0; g < fbc_pkg::PLANE_COUNT; g++) begin : g_cell
        fbc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_plane (w_next[g]),
            .o_plane (w_plane[g])
        );
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_vis       <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_vis   <= 1'b0;
        end else begin
            // in done the result register is reloaded below instead
            if (o_res.valid && o_res.ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end
            if (w_test_out.valid) begin
                r_vis <= r_vis & w_inside;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept && i_req.operation == fbc_pkg::OP_BUILD) begin
                        r_state <= ST_BUILD;
                    end else if (w_accept && i_req.operation == fbc_pkg::OP_TEST) begin
                        r_state <= ST_TEST;
                        r_vis   <= 1'b1;
                    end
                end
                ST_BUILD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (w_gen_in.last) begin
                        r_state <= ST_BDRAIN;
                    end
                end
                ST_BDRAIN: begin
                    if (w_gen_out.valid && w_gen_out.last) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_TEST: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (w_test_in.last) begin
                        r_state <= ST_TDRAIN;
                    end
                end
                ST_TDRAIN: begin
                    if (w_test_out.valid && w_test_out.last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_vis   <= r_vis;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: hdl/fbc_cell.sv
// one plane cell of the rotating plane chain
module fbc_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_shift,
    input  fbc_pkg::t_plane i_plane,
    output fbc_pkg::t_plane o_plane
);
    fbc_pkg::t_plane r_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_shift) begin
            r_plane <= i_plane;
        end
    end

    assign o_plane = r_plane;
endmodule

FILE: hdl/fbc_gen.sv
// plane coefficient generator: four products, exact sum, floor shift
module fbc_gen (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  fbc_pkg::t_gen_tag                        i_tag,
    input  logic signed [3:0][fbc_pkg::PSUM_W-1:0]   i_psum,
    input  logic [3:0][fbc_pkg::COORD_W-1:0]         i_view,
    output fbc_pkg::t_gen_tag                        o_tag,
    output fbc_pkg::t_coef                           o_coef
);
    logic signed [fbc_pkg::PROD_W-1:0] r_prod [4];
    fbc_pkg::t_gen_tag                 r_tag1;
    fbc_pkg::t_gen_tag                 r_tag2;
    fbc_pkg::t_coef                    r_coef;
    logic signed [fbc_pkg::ACC_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_prod[k] <= $signed(i_psum[k]) * $signed(i_view[k]);
        end
    end

    always_comb begin
        n_acc = '0;
        for (int k = 0; k < 4; k++) begin
            n_acc = n_acc + fbc_pkg::ACC_W'(r_prod[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_coef <= n_acc[fbc_pkg::ACC_W-1:fbc_pkg::FRACTION_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
        end else begin
            r_tag1 <= i_tag;
            r_tag2 <= r_tag1;
        end
    end

    assign o_tag  = r_tag2;
    assign o_coef = r_coef;
endmodule

FILE: hdl/fbc_test.sv
// box against one plane: best corner per axis, sum, sign test
module fbc_test (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fbc_pkg::t_test_tag i_tag,
    input  fbc_pkg::t_plane    i_plane,
    input  fbc_pkg::t_box      i_box,
    output fbc_pkg::t_test_tag o_tag,
    output logic               o_inside
);
    localparam int PHI_W = fbc_pkg::COORD_W + fbc_pkg::HI_W;
    localparam int PLO_W = fbc_pkg::COORD_W + fbc_pkg::LO_W + 1;

    logic signed [fbc_pkg::COORD_W-1:0] w_pt [3][2];
    logic signed [fbc_pkg::HI_W-1:0]    w_hi [3];
    logic signed [fbc_pkg::LO_W:0]      w_lo [3];
    logic signed [PHI_W-1:0]            r_phi [3][2];
    logic signed [PLO_W-1:0]            r_plo [3][2];
    fbc_pkg::t_coef                     r_d1;
    fbc_pkg::t_coef                     r_d2;
    logic signed [fbc_pkg::TERM_W-1:0]  n_term [3][2];
    logic signed [fbc_pkg::TERM_W-1:0]  r_best [3];
    logic signed [fbc_pkg::SUM_W-1:0]   n_sum;
    fbc_pkg::t_test_tag                 r_tag [3];
    logic                               r_inside;

    always_comb begin
        w_pt[0][0] = i_box.min_x;
        w_pt[0][1] = i_box.max_x;
        w_pt[1][0] = i_box.min_y;
        w_pt[1][1] = i_box.max_y;
        w_pt[2][0] = i_box.min_z;
        w_pt[2][1] = i_box.max_z;
        for (int a = 0; a < 3; a++) begin
            w_hi[a] = $signed(i_plane[a][fbc_pkg::COEF_W-1:fbc_pkg::LO_W]);
            w_lo[a] = $signed({1'b0, i_plane[a][fbc_pkg::LO_W-1:0]});
        end
    end

    // split multiply: high part signed, low part unsigned
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            for (int s = 0; s < 2; s++) begin
                r_phi[a][s] <= w_pt[a][s] * w_hi[a];
                r_plo[a][s] <= w_pt[a][s] * w_lo[a];
            end
        end
        r_d1 <= $signed(i_plane[3]);
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int s = 0; s < 2; s++) begin
                n_term[a][s] = (fbc_pkg::TERM_W'(r_phi[a][s]) <<< fbc_pkg::LO_W)
                             + fbc_pkg::TERM_W'(r_plo[a][s]);
            end
        end
    end

    // sum of per-axis maxima equals the best corner
    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_best[a] <= (n_term[a][1] > n_term[a][0]) ? n_term[a][1] : n_term[a][0];
        end
        r_d2 <= r_d1;
    end

    always_comb begin
        n_sum = (fbc_pkg::SUM_W'(r_d2) <<< fbc_pkg::FRACTION_BITS);
        for (int a = 0; a < 3; a++) begin
            n_sum = n_sum + fbc_pkg::SUM_W'(r_best[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside <= !n_sum[fbc_pkg::SUM_W-1] && (n_sum != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag[0] <= '0;
            r_tag[1] <= '0;
            r_tag[2] <= '0;
        end else begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
        end
    end

    assign o_tag    = r_tag[2];
    assign o_inside = r_inside;
endmodule

FILE: tb/sv/testbench.sv
// self-checking testbench of the frustum box cull block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        logic [1:0]         op;
        logic [3:0]         idx;
        logic signed [31:0] val;
        fbc_pkg::t_box      box;
    } t_cull_req;

    class cull_scoreboard;
        logic [63:0] proj_pair [8];
        logic [31:0] view_elem [16];
        logic [63:0] plane_coef [24];
        bit          visible_q [$];
        int          mismatches;

        function new();
            foreach (proj_pair[i]) proj_pair[i] = '0;
            foreach (view_elem[i]) view_elem[i] = '0;
            foreach (plane_coef[i]) plane_coef[i] = '0;
            mismatches = 0;
        endfunction

        function void set_projection(int k, logic [63:0] v);
            proj_pair[k] = v;
        endfunction

        function logic signed [127:0] ext32(logic [31:0] v);
            return {{96{v[31]}}, v};
        endfunction

        // exact product element scaled by 2^32
        function logic signed [127:0] product_elem(int col, int row);
            logic signed [127:0] acc;
            logic signed [127:0] a;
            logic signed [127:0] b;
            logic [63:0]         pr;
            int                  e;
            acc = '0;
            for (int k = 0; k < 4; k++) begin
                e  = k * 4 + row;
                pr = proj_pair[e >> 1];
                a  = ext32(e[0] ? pr[63:32] : pr[31:0]);
                b  = ext32(view_elem[col * 4 + k]);
                acc = acc + a * b;
            end
            return acc;
        endfunction

        function void build_planes();
            logic signed [127:0] w;
            logic signed [127:0] o;
            logic [1:0]          row;
            for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin
                row = (p < 2) ? 2'd0 : (p < 4) ? 2'd1 : 2'd2;
                for (int c = 0; c < 4; c++) begin
                    w = product_elem(c, 3);
                    o = product_elem(c, row);
                    if (p == 1 || p == 2 || p == 5) w = w - o;
                    else w = w + o;
                    w = w >>> fbc_pkg::FRACTION_BITS;
                    plane_coef[p * 4 + c] = w[63:0];
                end
            end
        endfunction

        function bit box_in_view(fbc_pkg::t_box bx);
            logic signed [127:0] acc;
            logic signed [127:0] x, y, z, pa, pb, pc, pd;
            bit                  hit;
            for (int p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin
                pa  = {{64{plane_coef[p*4][63]}}, plane_coef[p*4]};
                pb  = {{64{plane_coef[p*4+1][63]}}, plane_coef[p*4+1]};
                pc  = {{64{plane_coef[p*4+2][63]}}, plane_coef[p*4+2]};
                pd  = {{64{plane_coef[p*4+3][63]}}, plane_coef[p*4+3]};
                hit = 0;
                for (int k = 0; k < 8; k++) begin
                    x   = ext32(k[0] ? bx.max_x : bx.min_x);
                    y   = ext32(k[1] ? bx.max_y : bx.min_y);
                    z   = ext32(k[2] ? bx.max_z : bx.min_z);
                    acc = x * pa + y * pb + z * pc + (pd <<< fbc_pkg::FRACTION_BITS);
                    if (acc > 0) hit = 1;
                end
                if (!hit) return 0;
            end
            return 1;
        endfunction

        function void note_request(t_cull_req r);
            case (r.op)
                fbc_pkg::OP_LOAD:  view_elem[r.idx] = r.val;
                fbc_pkg::OP_BUILD: build_planes();
                fbc_pkg::OP_TEST:  visible_q.push_back(box_in_view(r.box));
                default: ;
            endcase
        endfunction

        function void check_result(logic vis);
            bit exp_vis;
            if (visible_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result box_visible=%0b", vis);
                return;
            end
            exp_vis = visible_q.pop_front();
            if (vis !== exp_vis) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("box_visible mismatch: expected %0b actual %0b", exp_vis, vis);
            end
        endfunction

        function int pending();
            return visible_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    fbc_req_if req_ch ();
    fbc_res_if res_ch ();

    frustum_box_cull DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cull_scoreboard sb;
    bit calm;
    bit hold_request;
    int idle_cycles;

    initial i_clk = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        res_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.box_visible);
            if (hold_request) begin
                hold_request = 0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                res_ch.ready <= 0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_ch.ready <= 0;
                stall_left--;
            end else begin
                res_ch.ready <= 1;
                stall_left = gap_len();
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send_request(t_cull_req r);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            req_ch.valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.operation     <= r.op;
        req_ch.element_index <= r.idx;
        req_ch.element_value <= r.val;
        req_ch.box_min_x     <= r.box.min_x;
        req_ch.box_min_y     <= r.box.min_y;
        req_ch.box_min_z     <= r.box.min_z;
        req_ch.box_max_x     <= r.box.max_x;
        req_ch.box_max_y     <= r.box.max_y;
        req_ch.box_max_z     <= r.box.max_z;
        req_ch.valid         <= 1;
        do @(posedge i_clk); while (!req_ch.ready);
        sb.note_request(r);
    endtask

    // drain results, then allow a build in flight to finish
    task automatic wait_idle();
        req_ch.valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_projection(logic [63:0] pairs [8]);
        wait_idle();
        for (int k = 0; k < 8; k++) begin
            cfg_we    <= 1;
            cfg_index <= k[2:0];
            cfg_data  <= pairs[k];
            @(posedge i_clk);
            sb.set_projection(k, pairs[k]);
        end
        cfg_we <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 262144) - 131072;
        if (r < 80) return (r[0]) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(0, 2097152) - 1048576;
        if (r < 83) return (r[0]) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic t_cull_req make_req(logic [1:0] op);
        t_cull_req r;
        logic [31:0] a, b;
        r.op  = op;
        r.idx = 4'($urandom_range(0, 15));
        r.val = $urandom;
        for (int i = 0; i < 3; i++) begin
            a = rand_coord();
            b = rand_coord();
            // mostly ordered corners, sometimes min above max
            if ($urandom_range(0, 9) != 0 && $signed(a) > $signed(b)) begin
                a = a ^ b; b = a ^ b; a = a ^ b;
            end
            case (i)
                0: begin r.box.min_x = a; r.box.max_x = b; end
                1: begin r.box.min_y = a; r.box.max_y = b; end
                default: begin r.box.min_z = a; r.box.max_z = b; end
            endcase
        end
        return r;
    endfunction

    task automatic load_view(bit identity);
        t_cull_req r;
        for (int e = 0; e < 16; e++) begin
            r = make_req(fbc_pkg::OP_LOAD);
            r.idx = 4'(e);
            if (identity) r.val = (e % 5 == 0) ? 32'h0001_0000 : 32'h0;
            else r.val = rand_value();
            send_request(r);
        end
        send_request(make_req(fbc_pkg::OP_BUILD));
    endtask

    initial begin
        logic [63:0] pairs [8];
        t_cull_req   r;
        int          n, pick;

        sb = new();
        calm = 0;
        hold_request = 0;
        i_rst_n = 0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 0;
        req_ch.operation = fbc_pkg::OP_LOAD;
        req_ch.element_index = '0;
        req_ch.element_value = '0;
        req_ch.box_min_x = '0;
        req_ch.box_min_y = '0;
        req_ch.box_min_z = '0;
        req_ch.box_max_x = '0;
        req_ch.box_max_y = '0;
        req_ch.box_max_z = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // test before any build, unused operation
        send_request(make_req(fbc_pkg::OP_TEST));
        send_request(make_req(OP_NONE));
        send_request(make_req(fbc_pkg::OP_TEST));

        // identity projection and view
        foreach (pairs[k]) pairs[k] = '0;
        pairs[0] = 64'h0000_0000_0001_0000;
        pairs[2] = 64'h0001_0000_0000_0000;
        pairs[5] = 64'h0000_0000_0001_0000;
        pairs[7] = 64'h0001_0000_0000_0000;
        write_projection(pairs);
        load_view(1);
        r = make_req(fbc_pkg::OP_TEST);
        r.box = '{32'shFFFF_0000, 32'shFFFF_0000, 32'shFFFF_0000,
                  32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000};
        send_request(r);
        r.box = '{32'sh0003_0000, 32'sh0003_0000, 32'sh0003_0000,
                  32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000};
        send_request(r);
        r.box = '{32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000,
                  32'shFFFF_0000, 32'shFFFF_0000, 32'shFFFF_0000};
        send_request(r);
        r.box = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        send_request(r);
        r.box = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
        send_request(r);

        for (int ph = 0; ph < 6; ph++) begin
            for (int k = 0; k < 8; k++) begin
                case (ph)
                    0: pairs[k] = {$urandom_range(0, 131072) - 65536,
                                   $urandom_range(0, 131072) - 65536};
                    1: pairs[k] = {$urandom_range(0, 262144) - 131072,
                                   $urandom_range(0, 262144) - 131072};
                    2: pairs[k] = 64'h7FFF_FFFF_8000_0000;
                    3: pairs[k] = 64'h8000_0000_7FFF_FFFF;
                    4: pairs[k] = 64'hFFFF_FFFF_FFFF_FFFF;
                    default: pairs[k] = {$urandom, $urandom};
                endcase
            end
            write_projection(pairs);
            calm = (ph == 2);
            load_view(0);
            if (ph == 1) hold_request = 1;
            n = 0;
            while (n < 80) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    load_view(0);
                    n += 17;
                end else if (pick < 14) begin
                    send_request(make_req(fbc_pkg::OP_LOAD));
                    n++;
                end else if (pick < 18) begin
                    send_request(make_req(fbc_pkg::OP_BUILD));
                    n++;
                end else if (pick < 21) begin
                    send_request(make_req(OP_NONE));
                end else begin
                    send_request(make_req(fbc_pkg::OP_TEST));
                    n++;
                end
            end
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
